@@ src/csc_pkg.sv @@
// Shared constants for the clock second-chance replacement block.
`default_nettype none

package csc_pkg;

    // Width of the frame index reported with each result.
    localparam int FIDX_W = 4;

    // Width of the frame-count configuration register.
    localparam int CFG_W = 5;

    // Frame count after reset.
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Width of the saturating fault counter.
    localparam int TOTAL_W = 32;

    // Saturation value of the fault counter.
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

endpackage

`default_nettype wire

@@ src/csc_channels.sv @@
// Valid/ready channel interfaces for references, results and configuration.
`default_nettype none

// Page reference channel.
interface csc_req_if #(
    parameter int PAGE_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink (input valid, input page_number, output ready);
endinterface

// Result channel.
interface csc_rsp_if #(
    parameter int PAGE_BITS = 16
);
    logic                        valid;
    logic                        ready;
    logic                        fault;
    logic [csc_pkg::FIDX_W-1:0]  frame_index;
    logic                        evicted_valid;
    logic [PAGE_BITS-1:0]        evicted_page;
    logic [csc_pkg::TOTAL_W-1:0] fault_total;

    modport source (output valid, output fault, output frame_index, output evicted_valid,
                    output evicted_page, output fault_total, input ready);
    modport sink (input valid, input fault, input frame_index, input evicted_valid,
                  input evicted_page, input fault_total, output ready);
endinterface

// Frame-count configuration write channel.
interface csc_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [csc_pkg::CFG_W-1:0]  frames_in_use;

    modport source (output valid, output frames_in_use, input ready);
    modport sink (input valid, input frames_in_use, output ready);
endinterface

`default_nettype wire

@@ src/csc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module csc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ src/csc_front.sv @@
// Front end: accepts page references into a two-entry queue.
`default_nettype none

module csc_front #(
    parameter int PAGE_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    csc_req_if.sink                   req,
    output logic                      q_valid,
    output logic [PAGE_BITS-1:0]      q_page,
    input  wire logic                 q_pop
);

    localparam logic [1:0] QDEPTH = 2'd2;

    logic [PAGE_BITS-1:0] entry_reg [2];
    logic                 wr_ptr_reg;
    logic                 wr_ptr_next;
    logic                 rd_ptr_reg;
    logic                 rd_ptr_next;
    logic [1:0]           count_reg;
    logic [1:0]           count_next;
    logic                 push;

    assign req.ready = (count_reg != QDEPTH);
    assign push      = req.valid && req.ready;
    assign q_valid   = (count_reg != 2'd0);
    assign q_page    = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage; a transfer writes the slot under the write pointer.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= req.page_number;
        end
    end

endmodule

`default_nettype wire

@@ src/csc_engine.sv @@
// Back end: hit search, clock sweep, frame update and result register.
`default_nettype none

module csc_engine #(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire logic [PAGE_BITS-1:0] q_page,
    output logic                      q_pop,
    csc_cfg_if.sink                   cfg,
    csc_rsp_if.source                 rsp
);

    import csc_pkg::*;

    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int HW = CW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SWEEP,
        S_EVICT,
        S_DONE
    } state_t;

    state_t                 state_reg,    state_next;
    logic [CFG_W-1:0]       fiu_reg,      fiu_next;
    logic [CW-1:0]          n_reg,        n_next;
    logic [PAGE_BITS-1:0]   page_reg,     page_next;
    logic [CW-1:0]          idx_reg,      idx_next;
    logic                   cmp_v_reg,    cmp_v_next;
    logic [IW-1:0]          cmp_idx_reg,  cmp_idx_next;
    logic [IW-1:0]          hand_reg,     hand_next;
    logic [MAX_FRAMES-1:0]  valid_reg,    valid_next;
    logic [MAX_FRAMES-1:0]  ref_reg,      ref_next;
    logic [TOTAL_W-1:0]     count_reg,    count_next;
    logic                   res_fault_reg,    res_fault_next;
    logic [FIDX_W-1:0]      res_frame_reg,    res_frame_next;
    logic                   res_ev_v_reg,     res_ev_v_next;
    logic [PAGE_BITS-1:0]   res_ev_page_reg,  res_ev_page_next;
    logic [TOTAL_W-1:0]     res_total_reg,    res_total_next;
    logic                   out_valid_reg,    out_valid_next;
    logic                   out_fault_reg,    out_fault_next;
    logic [FIDX_W-1:0]      out_frame_reg,    out_frame_next;
    logic                   out_ev_v_reg,     out_ev_v_next;
    logic [PAGE_BITS-1:0]   out_ev_page_reg,  out_ev_page_next;
    logic [TOTAL_W-1:0]     out_total_reg,    out_total_next;

    logic                   ram_we;
    logic [IW-1:0]          ram_raddr;
    logic [PAGE_BITS-1:0]   ram_rdata;
    logic [CW-1:0]          n_clamped;
    logic [HW-1:0]          hand_inc;
    logic [IW-1:0]          hand_wrap;
    logic                   hit;
    logic [TOTAL_W-1:0]     count_inc;

    // Page numbers of the frames.
    csc_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_page_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (hand_reg),
        .wdata (page_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg.ready         = 1'b1;
    assign rsp.valid         = out_valid_reg;
    assign rsp.fault         = out_fault_reg;
    assign rsp.frame_index   = out_frame_reg;
    assign rsp.evicted_valid = out_ev_v_reg;
    assign rsp.evicted_page  = out_ev_page_reg;
    assign rsp.fault_total   = out_total_reg;

    // Active frame count: zero acts as one, large values clamp to the ring size.
    always_comb
    begin
        if (fiu_reg == '0)
        begin
            n_clamped = CW'(1);
        end
        else if (32'(fiu_reg) > 32'(MAX_FRAMES))
        begin
            n_clamped = CW'(MAX_FRAMES);
        end
        else
        begin
            n_clamped = CW'(fiu_reg);
        end
    end

    // Hand advance with wrap at the active count, and saturating fault count.
    assign hand_inc  = HW'(hand_reg) + HW'(1);
    assign hand_wrap = (hand_inc == HW'(n_reg)) ? '0 : IW'(hand_inc);
    assign count_inc = (count_reg == TOTAL_MAX) ? count_reg : count_reg + TOTAL_W'(1);

    // A match needs the frame's valid mark; data of unwritten frames is ignored.
    assign hit = cmp_v_reg && valid_reg[cmp_idx_reg] && (ram_rdata == page_reg);

    // Sequencer for one reference at a time.
    always_comb
    begin
        state_next       = state_reg;
        fiu_next         = fiu_reg;
        n_next           = n_reg;
        page_next        = page_reg;
        idx_next         = idx_reg;
        cmp_v_next       = cmp_v_reg;
        cmp_idx_next     = cmp_idx_reg;
        hand_next        = hand_reg;
        valid_next       = valid_reg;
        ref_next         = ref_reg;
        count_next       = count_reg;
        res_fault_next   = res_fault_reg;
        res_frame_next   = res_frame_reg;
        res_ev_v_next    = res_ev_v_reg;
        res_ev_page_next = res_ev_page_reg;
        res_total_next   = res_total_reg;
        out_valid_next   = out_valid_reg;
        out_fault_next   = out_fault_reg;
        out_frame_next   = out_frame_reg;
        out_ev_v_next    = out_ev_v_reg;
        out_ev_page_next = out_ev_page_reg;
        out_total_next   = out_total_reg;
        ram_we           = 1'b0;
        ram_raddr        = hand_reg;
        q_pop            = 1'b0;

        // Configuration write.
        if (cfg.valid)
        begin
            fiu_next = cfg.frames_in_use;
        end

        // Output register drains on a transfer.
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    page_next  = q_page;
                    n_next     = n_clamped;
                    idx_next   = '0;
                    cmp_v_next = 1'b0;
                    state_next = S_SEARCH;
                end
            end

            // One frame read issued per cycle, compared in the next cycle.
            S_SEARCH:
            begin
                if (hit)
                begin
                    ref_next[cmp_idx_reg] = 1'b1;
                    res_fault_next        = 1'b0;
                    res_frame_next        = FIDX_W'(cmp_idx_reg);
                    res_ev_v_next         = 1'b0;
                    res_ev_page_next      = '0;
                    res_total_next        = count_reg;
                    state_next            = S_DONE;
                end
                else if (idx_reg < n_reg)
                begin
                    ram_raddr    = idx_reg[IW-1:0];
                    cmp_v_next   = 1'b1;
                    cmp_idx_next = idx_reg[IW-1:0];
                    idx_next     = idx_reg + CW'(1);
                end
                else
                begin
                    // A hand left beyond a shrunken ring restarts at frame zero.
                    if (CW'(hand_reg) >= n_reg)
                    begin
                        hand_next = '0;
                    end
                    cmp_v_next = 1'b0;
                    state_next = S_SWEEP;
                end
            end

            // Clear set reference bits until a clear one is under the hand.
            S_SWEEP:
            begin
                if (ref_reg[hand_reg])
                begin
                    ref_next[hand_reg] = 1'b0;
                    hand_next          = hand_wrap;
                end
                else
                begin
                    ram_raddr  = hand_reg;
                    state_next = S_EVICT;
                end
            end

            // Report the old page and install the new one in the victim frame.
            S_EVICT:
            begin
                res_fault_next       = 1'b1;
                res_frame_next       = FIDX_W'(hand_reg);
                res_ev_v_next        = valid_reg[hand_reg];
                res_ev_page_next     = valid_reg[hand_reg] ? ram_rdata : '0;
                res_total_next       = count_inc;
                count_next           = count_inc;
                ram_we               = 1'b1;
                valid_next[hand_reg] = 1'b1;
                ref_next[hand_reg]   = 1'b0;
                hand_next            = hand_wrap;
                state_next           = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_fault_next   = res_fault_reg;
                    out_frame_next   = res_frame_reg;
                    out_ev_v_next    = res_ev_v_reg;
                    out_ev_page_next = res_ev_page_reg;
                    out_total_next   = res_total_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fiu_reg       <= CFG_RESET;
            cmp_v_reg     <= 1'b0;
            hand_reg      <= '0;
            valid_reg     <= '0;
            ref_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fiu_reg       <= fiu_next;
            cmp_v_reg     <= cmp_v_next;
            hand_reg      <= hand_next;
            valid_reg     <= valid_next;
            ref_reg       <= ref_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        n_reg           <= n_next;
        page_reg        <= page_next;
        idx_reg         <= idx_next;
        cmp_idx_reg     <= cmp_idx_next;
        res_fault_reg   <= res_fault_next;
        res_frame_reg   <= res_frame_next;
        res_ev_v_reg    <= res_ev_v_next;
        res_ev_page_reg <= res_ev_page_next;
        res_total_reg   <= res_total_next;
        out_fault_reg   <= out_fault_next;
        out_frame_reg   <= out_frame_next;
        out_ev_v_reg    <= out_ev_v_next;
        out_ev_page_reg <= out_ev_page_next;
        out_total_reg   <= out_total_next;
    end

endmodule

`default_nettype wire

@@ src/clock_second_chance_replacement.sv @@
// Top level of the clock second-chance page replacement block.
//
// Each page reference transferred on req gives exactly one result on rsp. A
// two-entry queue takes references while the back end works on an earlier one,
// and the result waits in an output register, so neither side blocks the other
// directly. The back end handles one reference at a time. During the hit
// search it walks the frames one per cycle through the single read port of the
// page-number RAM, and on a miss it then steps the clock hand one frame per
// cycle. No clearing pass is needed after reset. The frame count register is
// written on cfg and takes effect with the next reference.
`default_nettype none

module clock_second_chance_replacement #(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    csc_req_if.sink   req,
    csc_rsp_if.source rsp,
    csc_cfg_if.sink   cfg
);

    logic                 q_valid;
    logic [PAGE_BITS-1:0] q_page;
    logic                 q_pop;

    // Accept and queue references.
    csc_front #(
        .PAGE_BITS (PAGE_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_page  (q_page),
        .q_pop   (q_pop)
    );

    // Search, sweep and report.
    csc_engine #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_page  (q_page),
        .q_pop   (q_pop),
        .cfg     (cfg),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire

@@ src/csc_checker.sv @@
// Port-level checks for the clock second-chance replacement block.
`default_nettype none

module csc_checker #(
    parameter int PAGE_BITS = 16
) (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        req_valid,
    input wire logic                        req_ready,
    input wire logic                        rsp_valid,
    input wire logic                        rsp_ready,
    input wire logic                        fault,
    input wire logic                        evicted_valid,
    input wire logic [PAGE_BITS-1:0]        evicted_page,
    input wire logic [csc_pkg::TOTAL_W-1:0] fault_total
);

    import csc_pkg::*;

    logic [3:0]         pending_reg;
    logic [3:0]         pending_next;
    logic [TOTAL_W-1:0] last_total_reg;
    logic [TOTAL_W-1:0] exp_total;
    logic               in_xfer;
    logic               out_xfer;

    assign in_xfer  = req_valid && req_ready;
    assign out_xfer = rsp_valid && rsp_ready;

    // References accepted but not yet answered.
    always_comb
    begin
        pending_next = pending_reg;
        if (in_xfer && !out_xfer)
        begin
            pending_next = pending_reg + 4'd1;
        end
        else if (out_xfer && !in_xfer)
        begin
            pending_next = pending_reg - 4'd1;
        end
    end

    // Expected fault total of a result, given the total of the one before.
    always_comb
    begin
        if (!fault)
        begin
            exp_total = last_total_reg;
        end
        else if (last_total_reg == TOTAL_MAX)
        begin
            exp_total = TOTAL_MAX;
        end
        else
        begin
            exp_total = last_total_reg + TOTAL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            last_total_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (out_xfer)
            begin
                last_total_reg <= fault_total;
            end
        end
    end

    // A stalled result stays offered with its fault total and evicted page unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(fault_total)
            && $stable(evicted_page))
        else $error("result changed while stalled");

    // No result appears without an outstanding reference.
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 4'd0)
        else $error("result without a pending reference");

    // A hit never reports an eviction.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !fault |-> !evicted_valid && evicted_page == '0)
        else $error("eviction reported on a hit");

    // The fault total steps by one on a fault and saturates.
    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> fault_total == exp_total)
        else $error("fault total out of sequence");

endmodule

bind clock_second_chance_replacement csc_checker #(
    .PAGE_BITS (PAGE_BITS)
) u_csc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .fault         (rsp.fault),
    .evicted_valid (rsp.evicted_valid),
    .evicted_page  (rsp.evicted_page),
    .fault_total   (rsp.fault_total)
);

`default_nettype wire
